### design/hlva_pkg.sv
package hlva_pkg;

   localparam int ANGLES              = 7;
   localparam int RHO_BINS            = 256;
   localparam int ANGLE_W             = 3;
   localparam int BIN_W               = 8;
   localparam int COUNT_W             = 8;
   localparam int COL_W               = 8;
   localparam int ROW_W               = 10;
   localparam int EDGE_W              = 8;
   localparam int OFFSET_W            = 8;
   localparam int MEM_DEPTH           = ANGLES * RHO_BINS;
   localparam int ADDR_W              = ANGLE_W + BIN_W;
   localparam int LINE_WIDTH_DEF      = 256;
   localparam int COEF_FRAC_BITS_DEF  = 20;
   localparam int MIN_ROW             = 6;
   localparam int EDGE_VOTE           = 1;
   localparam int COL_MARGIN          = 6;
   localparam int OFFSET_RESET        = 128;
   localparam longint MICRO_SCALE     = 1000000;
   // multiplier operand: widest of column and row distance, plus a zero sign bit
   localparam int OPA_W               = ROW_W + 1;

   localparam int COS_MICRO [ANGLES] = '{998630, 999391, 999848, 1000000,
                                         999848, 999391, 998630};
   localparam int SIN_MICRO [ANGLES] = '{-52336, -34899, -17452, 0,
                                         17452, 34899, 52336};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_C,
      ST_MUL_S,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic en;
      logic sel_sin;
   } mac_ctrl_type;

   typedef struct packed {
      logic wr_even;
      logic wr_odd;
      logic rd_odd;
   } mem_ctrl_type;

   // round micro units to frac fraction bits, nearest with ties upward
   function automatic longint round_coef(input int micro, input int frac);
      longint num;
      num = longint'(micro) * (longint'(1) << frac) + MICRO_SCALE / 2;
      if (num >= 0) begin
         return num / MICRO_SCALE;
      end
      return -((-num + MICRO_SCALE - 1) / MICRO_SCALE);
   endfunction

endpackage

### design/hlva_mac.sv
module hlva_mac import hlva_pkg::*; #(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   input  logic [ANGLE_W-1:0]      angle,
   input  logic [COL_W-1:0]        column,
   input  logic [ROW_W-1:0]        dy,
   input  logic [OFFSET_W-1:0]     offset,
   output logic [BIN_W-1:0]        bin
);

   localparam int CW    = COEF_FRAC_BITS + 2;
   localparam int ACC_W = COEF_FRAC_BITS + BIN_W;
   localparam int MW    = OPA_W + CW;

   localparam logic signed [CW-1:0] COS_TAB [ANGLES] = '{
      CW'(round_coef(COS_MICRO[0], COEF_FRAC_BITS)),
      CW'(round_coef(COS_MICRO[1], COEF_FRAC_BITS)),
      CW'(round_coef(COS_MICRO[2], COEF_FRAC_BITS)),
      CW'(round_coef(COS_MICRO[3], COEF_FRAC_BITS)),
      CW'(round_coef(COS_MICRO[4], COEF_FRAC_BITS)),
      CW'(round_coef(COS_MICRO[5], COEF_FRAC_BITS)),
      CW'(round_coef(COS_MICRO[6], COEF_FRAC_BITS))};

   localparam logic signed [CW-1:0] SIN_TAB [ANGLES] = '{
      CW'(round_coef(SIN_MICRO[0], COEF_FRAC_BITS)),
      CW'(round_coef(SIN_MICRO[1], COEF_FRAC_BITS)),
      CW'(round_coef(SIN_MICRO[2], COEF_FRAC_BITS)),
      CW'(round_coef(SIN_MICRO[3], COEF_FRAC_BITS)),
      CW'(round_coef(SIN_MICRO[4], COEF_FRAC_BITS)),
      CW'(round_coef(SIN_MICRO[5], COEF_FRAC_BITS)),
      CW'(round_coef(SIN_MICRO[6], COEF_FRAC_BITS))};

   localparam logic [COEF_FRAC_BITS-1:0] HALF = COEF_FRAC_BITS'(1) << (COEF_FRAC_BITS - 1);

   logic [ACC_W-1:0]        acc_ff;
   logic [ACC_W-1:0]        acc_in;
   logic [ACC_W-1:0]        base;
   logic [ACC_W-1:0]        addend;
   logic signed [OPA_W-1:0] opa;
   logic signed [CW-1:0]    coef;
   logic signed [MW-1:0]    prod;

   // offset plus one half, in the low ACC_W bits (sums wrap like the bin does)
   assign base = {offset, HALF};

   always_comb begin
      if (ctrl.sel_sin) begin
         opa    = $signed({1'b0, dy});
         coef   = SIN_TAB[angle];
         addend = acc_ff;
      end else begin
         opa    = $signed({{(OPA_W - COL_W){1'b0}}, column});
         coef   = COS_TAB[angle];
         addend = base;
      end
      prod   = opa * coef;
      acc_in = addend + prod[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign bin = acc_ff[ACC_W-1:COEF_FRAC_BITS];

endmodule

### design/hlva_vote_mem.sv
module hlva_vote_mem import hlva_pkg::*; (
   input  logic                 clock,
   input  mem_ctrl_type         ctrl,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [COUNT_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [COUNT_W-1:0]   rd_data
);

   logic [COUNT_W-1:0] even_mem [MEM_DEPTH];
   logic [COUNT_W-1:0] odd_mem  [MEM_DEPTH];
   logic [COUNT_W-1:0] rd_even_ff;
   logic [COUNT_W-1:0] rd_odd_ff;
   logic               rd_sel_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_even) begin
         even_mem[wr_addr] <= wr_data;
      end
      if (ctrl.wr_odd) begin
         odd_mem[wr_addr] <= wr_data;
      end
      rd_even_ff <= even_mem[rd_addr];
      rd_odd_ff  <= odd_mem[rd_addr];
      rd_sel_ff  <= ctrl.rd_odd;
   end

   assign rd_data = rd_sel_ff ? rd_odd_ff : rd_even_ff;

endmodule

### design/hough_line_vote_accumulator_unit.sv
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+--------------------------
// request  | req_column, req_row, req_edge_value           | start while busy is low
// response | rsp_angle_index, rsp_odd_bank, rsp_rho_bin,   | rsp_valid, one cycle each
//          | rsp_vote_count, rsp_last_vote                 |
// config   | csr_wr_data (rho offset)                      | csr_wr_en
//
// a voting item is accepted in ST_IDLE, then each angle runs ST_MUL_C and ST_MUL_S
// (two passes through the shared multiply-add), ST_READ (one memory read) and ST_WRITE
// (one read-modify-write); a non-voting item is dropped in its accept cycle
// after reset the vote banks are cleared one address a cycle, busy until all 1792 are written
// results come in the write cycles, one per angle; the receiver cannot stall
module hough_line_vote_accumulator_unit import hlva_pkg::*; #(
   parameter int LINE_WIDTH     = LINE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [COL_W-1:0]     req_column,
   input  logic [ROW_W-1:0]     req_row,
   input  logic [EDGE_W-1:0]    req_edge_value,
   output logic                 rsp_valid,
   output logic [ANGLE_W-1:0]   rsp_angle_index,
   output logic                 rsp_odd_bank,
   output logic [BIN_W-1:0]     rsp_rho_bin,
   output logic [COUNT_W-1:0]   rsp_vote_count,
   output logic                 rsp_last_vote,
   input  logic                 csr_wr_en,
   input  logic [OFFSET_W-1:0]  csr_wr_data
);

   localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(LINE_WIDTH - COL_MARGIN);

   state_type            state_ff, state_in;
   logic [ANGLE_W-1:0]   angle_ff, angle_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [OFFSET_W-1:0]  offset_ff;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     dy_ff, dy_in;
   logic                 odd_ff, odd_in;

   mac_ctrl_type         mac_ctrl;
   mem_ctrl_type         mem_ctrl;
   logic [BIN_W-1:0]     bin;
   logic [ADDR_W-1:0]    vote_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [COUNT_W-1:0]   wr_data;
   logic [COUNT_W-1:0]   rd_data;
   logic [COUNT_W-1:0]   new_count;
   logic                 vote_ok;

   assign vote_ok = (req_edge_value == EDGE_W'(EDGE_VOTE))
                 && (req_row >= ROW_W'(MIN_ROW))
                 && ({1'b0, req_column} < COL_LIMIT);

   assign vote_addr = {angle_ff, bin};
   assign new_count = rd_data + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         angle_ff  <= '0;
         clr_ff    <= '0;
         offset_ff <= OFFSET_W'(OFFSET_RESET);
      end else begin
         state_ff <= state_in;
         angle_ff <= angle_in;
         clr_ff   <= clr_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      dy_ff  <= dy_in;
      odd_ff <= odd_in;
   end

   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      dy_in        = dy_ff;
      odd_in       = odd_ff;
      mac_ctrl     = '0;
      mem_ctrl     = '0;
      mem_ctrl.rd_odd = odd_ff;
      wr_addr      = vote_addr;
      wr_data      = new_count;
      rsp_valid    = 1'b0;
      busy         = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctrl.wr_even = 1'b1;
            mem_ctrl.wr_odd  = 1'b1;
            wr_addr          = clr_ff;
            wr_data          = '0;
            clr_in           = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start && vote_ok) begin
               col_in   = req_column;
               dy_in    = req_row - ROW_W'(MIN_ROW);
               odd_in   = req_column[0];
               angle_in = '0;
               state_in = ST_MUL_C;
            end
         end
         ST_MUL_C: begin
            mac_ctrl.en = 1'b1;
            state_in    = ST_MUL_S;
         end
         ST_MUL_S: begin
            mac_ctrl.en      = 1'b1;
            mac_ctrl.sel_sin = 1'b1;
            state_in         = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_ctrl.wr_even = !odd_ff;
            mem_ctrl.wr_odd  = odd_ff;
            rsp_valid        = 1'b1;
            if (angle_ff == ANGLE_W'(ANGLES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               angle_in = angle_ff + ANGLE_W'(1);
               state_in = ST_MUL_C;
            end
         end
         default: begin
            clr_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   hlva_mac #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .angle  (angle_ff),
      .column (col_ff),
      .dy     (dy_ff),
      .offset (offset_ff),
      .bin    (bin)
   );

   hlva_vote_mem u_mem (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (vote_addr),
      .rd_data (rd_data)
   );

   assign rsp_angle_index = angle_ff;
   assign rsp_odd_bank    = odd_ff;
   assign rsp_rho_bin     = bin;
   assign rsp_vote_count  = new_count;
   assign rsp_last_vote   = (angle_ff == ANGLE_W'(ANGLES - 1));

endmodule
